// ----- src/bitmap_text_sprite_layout_core_macros.svh -----
// Assertion helpers for the text sprite layout core.
`ifndef BITMAP_TEXT_SPRITE_LAYOUT_CORE_MACROS_SVH
`define BITMAP_TEXT_SPRITE_LAYOUT_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Antecedent implies consequent in the same cycle.
`define BTSL_ASSERT_SAME(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("btsl check failed: same-cycle implication");
// Antecedent implies consequent in the next cycle.
`define BTSL_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("btsl check failed: next-cycle implication");
`else
`define BTSL_ASSERT_SAME(name, clk, rstn, ante, cons)
`define BTSL_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif

`endif

// ----- src/btsl_pkg.sv -----
`default_nettype none

package btsl_pkg;

  localparam int unsigned GlyphCountDef = 96;
  localparam int unsigned FirstCodeDef  = 32;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 8;
  localparam int unsigned PixW    = 8;
  localparam int unsigned IndexW  = 7;
  localparam int unsigned AtlasW  = 12;
  localparam int unsigned FixW    = 24;
  localparam int unsigned TexW    = 20;
  localparam int unsigned LineW   = 16;

  localparam logic [7:0] NewlineCode = 8'd10;

  localparam logic [CfgW-1:0] LineHeightRst = 8'd16;
  localparam logic [CfgW-1:0] AscenderRst   = 8'd12;
  localparam logic [CfgW-1:0] TexelInsetRst = 8'd26;

  typedef enum logic [CmdW-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BEGIN = 2'd1,
    CMD_CHAR  = 2'd2
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LINE_HEIGHT = 2'd0,
    CFG_ASCENDER    = 2'd1,
    CFG_TEXEL_INSET = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [PixW-1:0] advance;
    logic [PixW-1:0] bearing_y;
    logic [PixW-1:0] bearing_x;
    logic [PixW-1:0] height;
    logic [PixW-1:0] width;
  } glyph_shape_t;

  typedef struct packed {
    logic [AtlasW-1:0] atlas_y;
    logic [AtlasW-1:0] atlas_x;
  } glyph_place_t;

  typedef struct packed {
    logic             drawn;
    logic [FixW-1:0]  dest_x;
    logic [FixW-1:0]  dest_y;
    logic [FixW-1:0]  dest_x_end;
    logic [FixW-1:0]  dest_y_end;
    logic [TexW-1:0]  tex_u0;
    logic [TexW-1:0]  tex_v0;
    logic [TexW-1:0]  tex_u1;
    logic [TexW-1:0]  tex_v1;
    logic [LineW-1:0] line_width;
  } result_t;

endpackage

`default_nettype wire

// ----- src/btsl_if.sv -----
`default_nettype none

interface btsl_item_if;
  import btsl_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CmdW-1:0]          command;
  logic [IndexW-1:0]        glyph_index;
  logic [PixW-1:0]          glyph_width;
  logic [PixW-1:0]          glyph_height;
  logic signed [PixW-1:0]   bearing_x;
  logic signed [PixW-1:0]   bearing_y;
  logic [PixW-1:0]          advance;
  logic [AtlasW-1:0]        atlas_x;
  logic [AtlasW-1:0]        atlas_y;
  logic signed [FixW-1:0]   origin_x;
  logic signed [FixW-1:0]   origin_y;
  logic [7:0]               char_code;

  modport source (
    output valid, command, glyph_index, glyph_width, glyph_height, bearing_x,
           bearing_y, advance, atlas_x, atlas_y, origin_x, origin_y, char_code,
    input  ready
  );
  modport sink (
    input  valid, command, glyph_index, glyph_width, glyph_height, bearing_x,
           bearing_y, advance, atlas_x, atlas_y, origin_x, origin_y, char_code,
    output ready
  );
endinterface

interface btsl_result_if;
  import btsl_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   drawn;
  logic signed [FixW-1:0] dest_x;
  logic signed [FixW-1:0] dest_y;
  logic signed [FixW-1:0] dest_x_end;
  logic signed [FixW-1:0] dest_y_end;
  logic [TexW-1:0]        tex_u0;
  logic [TexW-1:0]        tex_v0;
  logic [TexW-1:0]        tex_u1;
  logic [TexW-1:0]        tex_v1;
  logic [LineW-1:0]       line_width;

  modport source (
    output valid, drawn, dest_x, dest_y, dest_x_end, dest_y_end, tex_u0, tex_v0,
           tex_u1, tex_v1, line_width,
    input  ready
  );
  modport sink (
    input  valid, drawn, dest_x, dest_y, dest_x_end, dest_y_end, tex_u0, tex_v0,
           tex_u1, tex_v1, line_width,
    output ready
  );
endinterface

interface btsl_cfg_if;
  import btsl_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- src/bitmap_text_sprite_layout_core.sv -----
// Channel   Dir  Handshake            Beat
// item_i    in   item_i.valid/ready   one command: load, begin or character
// result_o  out  result_o.valid/ready one result per accepted item
// cfg_i     in   cfg_i.valid/ready    register write (index, data), always ready
//
// One item per cycle while the output does not stall; an accepted item passes through the
// stage 1 registers and then the output register. The glyph table read (one registered
// read port) sets the first stage, the pen update and quad arithmetic the second.
// Reset clears pen and width and restores the configuration registers to their defaults;
// the glyph tables are not cleared. A stalled output holds one result and the stage behind it, then item_i drops ready.
`default_nettype none

module bitmap_text_sprite_layout_core #(
  parameter int unsigned GLYPH_COUNT = btsl_pkg::GlyphCountDef,
  parameter int unsigned FIRST_CODE  = btsl_pkg::FirstCodeDef
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  btsl_item_if.sink     item_i,
  btsl_result_if.source result_o,
  btsl_cfg_if.sink      cfg_i
);
  import btsl_pkg::*;

  `include "bitmap_text_sprite_layout_core_macros.svh"

  localparam int unsigned AddrW = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

  // configuration
  logic [CfgW-1:0] line_height_q, ascender_q, texel_inset_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_height_q <= LineHeightRst;
      ascender_q    <= AscenderRst;
      texel_inset_q <= TexelInsetRst;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_LINE_HEIGHT: line_height_q <= cfg_i.data;
        CFG_ASCENDER:    ascender_q    <= cfg_i.data;
        CFG_TEXEL_INSET: texel_inset_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // handshake control
  logic s1_valid_q, out_valid_q;
  logic out_free, s1_adv, in_acc;

  assign out_free     = !out_valid_q || result_o.ready;
  assign s1_adv       = s1_valid_q && out_free;
  assign item_i.ready = !s1_valid_q || s1_adv;
  assign in_acc       = item_i.valid && item_i.ready;

  // decode at the input
  logic [8:0]       code_off;
  logic             code_in_range, is_newline, load_ok;
  logic [AddrW-1:0] wr_addr, rd_addr;

  assign code_off      = {1'b0, item_i.char_code} - 9'(FIRST_CODE);
  assign code_in_range = ({1'b0, item_i.char_code} >= 9'(FIRST_CODE)) &&
                         (code_off < 9'(GLYPH_COUNT));
  assign is_newline    = (item_i.char_code == NewlineCode);
  assign load_ok       = ({2'b00, item_i.glyph_index} < 9'(GLYPH_COUNT));
  assign wr_addr       = AddrW'({2'b00, item_i.glyph_index});
  assign rd_addr       = AddrW'(code_off);

  // glyph tables: write on an in-range load beat, read on any beat whose char_code is in range
  glyph_shape_t shape_mem [GLYPH_COUNT];
  glyph_place_t place_mem [GLYPH_COUNT];
  glyph_shape_t rd_shape_q;
  glyph_place_t rd_place_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && (cmd_e'(item_i.command) == CMD_LOAD) && load_ok) begin
      shape_mem[wr_addr] <= '{advance:   item_i.advance,
                              bearing_y: item_i.bearing_y,
                              bearing_x: item_i.bearing_x,
                              height:    item_i.glyph_height,
                              width:     item_i.glyph_width};
      place_mem[wr_addr] <= '{atlas_y: item_i.atlas_y, atlas_x: item_i.atlas_x};
    end
    if (in_acc && code_in_range) begin
      rd_shape_q <= shape_mem[rd_addr];
      rd_place_q <= place_mem[rd_addr];
    end
  end

  // stage 1 payload
  cmd_e            s1_cmd_q;
  logic            s1_newline_q, s1_glyph_q;
  logic [FixW-1:0] s1_origin_x_q, s1_origin_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cmd_q      <= cmd_e'(item_i.command);
      s1_newline_q  <= is_newline;
      s1_glyph_q    <= code_in_range && !is_newline;
      s1_origin_x_q <= item_i.origin_x;
      s1_origin_y_q <= item_i.origin_y;
    end
  end

  // pen state
  logic [FixW-1:0]  pen_x_q, pen_y_q, start_x_q;
  logic [FixW-1:0]  pen_x_d, pen_y_d, start_x_d;
  logic [LineW-1:0] wsf_q, wsf_d;
  result_t          res;

  always_comb begin
    logic [FixW-1:0]  bx_fx, by_fx, asc_fx, w_fx, h_fx, adv_fx, gx, gy;
    logic [TexW-1:0]  u0, v0;
    logic [TexW:0]    u1_sum, v1_sum;
    logic [LineW:0]   wsum;

    bx_fx  = {{8{rd_shape_q.bearing_x[7]}}, rd_shape_q.bearing_x, 8'h00};
    by_fx  = {{8{rd_shape_q.bearing_y[7]}}, rd_shape_q.bearing_y, 8'h00};
    asc_fx = {8'h00, ascender_q, 8'h00};
    w_fx   = {8'h00, rd_shape_q.width, 8'h00};
    h_fx   = {8'h00, rd_shape_q.height, 8'h00};
    adv_fx = {8'h00, rd_shape_q.advance, 8'h00};
    gx     = pen_x_q + bx_fx;
    gy     = pen_y_q + asc_fx - by_fx;
    u0     = {rd_place_q.atlas_x, 8'h00};
    v0     = {rd_place_q.atlas_y, 8'h00};
    u1_sum = {1'b0, u0} + {5'b0, rd_shape_q.width, 8'h00} - {13'b0, texel_inset_q};
    v1_sum = {1'b0, v0} + {5'b0, rd_shape_q.height, 8'h00} - {13'b0, texel_inset_q};
    wsum   = {1'b0, wsf_q} + {9'b0, rd_shape_q.advance};

    pen_x_d   = pen_x_q;
    pen_y_d   = pen_y_q;
    start_x_d = start_x_q;
    wsf_d     = wsf_q;
    res       = '0;

    case (s1_cmd_q)
      CMD_BEGIN: begin
        pen_x_d   = s1_origin_x_q;
        start_x_d = s1_origin_x_q;
        pen_y_d   = s1_origin_y_q;
        wsf_d     = '0;
      end
      CMD_CHAR: begin
        if (s1_newline_q) begin
          pen_x_d = start_x_q;
          pen_y_d = pen_y_q + {8'h00, line_height_q, 8'h00};
          wsf_d   = '0;
        end else if (s1_glyph_q) begin
          if ((rd_shape_q.width != '0) && (rd_shape_q.height != '0)) begin
            res.drawn      = 1'b1;
            res.dest_x     = gx;
            res.dest_y     = gy;
            res.dest_x_end = gx + w_fx;
            res.dest_y_end = gy + h_fx;
            res.tex_u0     = u0;
            res.tex_v0     = v0;
            res.tex_u1     = u1_sum[TexW] ? '1 : u1_sum[TexW-1:0];
            res.tex_v1     = v1_sum[TexW] ? '1 : v1_sum[TexW-1:0];
          end
          pen_x_d = pen_x_q + adv_fx;
          wsf_d   = wsum[LineW] ? '1 : wsum[LineW-1:0];
        end
      end
      default: ;
    endcase

    res.line_width = wsf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q   <= '0;
      pen_y_q   <= '0;
      start_x_q <= '0;
      wsf_q     <= '0;
    end else if (s1_adv) begin
      pen_x_q   <= pen_x_d;
      pen_y_q   <= pen_y_d;
      start_x_q <= start_x_d;
      wsf_q     <= wsf_d;
    end
  end

  // output register
  result_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= res;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.drawn      = out_q.drawn;
  assign result_o.dest_x     = out_q.dest_x;
  assign result_o.dest_y     = out_q.dest_y;
  assign result_o.dest_x_end = out_q.dest_x_end;
  assign result_o.dest_y_end = out_q.dest_y_end;
  assign result_o.tex_u0     = out_q.tex_u0;
  assign result_o.tex_v0     = out_q.tex_v0;
  assign result_o.tex_u1     = out_q.tex_u1;
  assign result_o.tex_v1     = out_q.tex_v1;
  assign result_o.line_width = out_q.line_width;

  `BTSL_ASSERT_SAME(a_ready_only_when_full, clk_i, rst_ni,
    !item_i.ready, s1_valid_q && out_valid_q && !result_o.ready)
  `BTSL_ASSERT_SAME(a_undrawn_is_zero, clk_i, rst_ni,
    out_valid_q && !out_q.drawn,
    (out_q.dest_x == '0) && (out_q.dest_y_end == '0) && (out_q.tex_u1 == '0))
  `BTSL_ASSERT_SAME(a_tex_far_edge, clk_i, rst_ni,
    out_valid_q && out_q.drawn,
    (out_q.tex_u1 > out_q.tex_u0) && (out_q.tex_v1 > out_q.tex_v0))
  `BTSL_ASSERT_NEXT(a_begin_clears_width, clk_i, rst_ni,
    s1_adv && (s1_cmd_q == CMD_BEGIN), out_valid_q && (out_q.line_width == '0))

endmodule

`default_nettype wire

// ----- tb/btsl_layout_checker.sv -----
`timescale 1ns / 1ps

module btsl_layout_checker #(
  parameter int unsigned GLYPH_COUNT = btsl_pkg::GlyphCountDef,
  parameter int unsigned FIRST_CODE  = btsl_pkg::FirstCodeDef
) (
  input  wire    clk_i,
  input  wire    rst_ni,
  btsl_item_if   item_i,
  btsl_result_if result_i,
  btsl_cfg_if    cfg_i,
  output int     fail_count_o,
  output int     pending_o
);
  import btsl_pkg::*;

  glyph_shape_t     shape_mem [GLYPH_COUNT];
  glyph_place_t     place_mem [GLYPH_COUNT];
  logic [FixW-1:0]  pen_x;
  logic [FixW-1:0]  pen_y;
  logic [FixW-1:0]  start_x;
  logic [LineW-1:0] line_acc;
  logic [CfgW-1:0]  line_height;
  logic [CfgW-1:0]  ascender;
  logic [CfgW-1:0]  texel_inset;
  result_t          expected_q [$];
  int               mismatches;
  bit               beat_bad;

  // Whole pixels to 16.8, optionally sign-extending the pixel value.
  function automatic logic [FixW-1:0] to_fixed(logic [PixW-1:0] pix, bit sext);
    return {{8{sext & pix[PixW-1]}}, pix, 8'h00};
  endfunction

  // Far texture edge: near edge plus size, pulled in by the inset, clamped.
  function automatic logic [TexW-1:0] tex_far(logic [TexW-1:0] near, logic [PixW-1:0] size);
    logic [TexW+1:0] far_sum;
    far_sum = {2'b00, near} + {6'd0, size, 8'h00} - {14'd0, texel_inset};
    return (far_sum > {2'b00, {TexW{1'b1}}}) ? {TexW{1'b1}} : far_sum[TexW-1:0];
  endfunction

  task automatic layout_item();
    glyph_shape_t     sh;
    glyph_place_t     pl;
    result_t          r;
    logic [FixW-1:0]  gx;
    logic [FixW-1:0]  gy;
    logic [LineW:0]   sum;
    logic [7:0]       code;
    int unsigned      slot;
    r = '0;
    code = item_i.char_code;
    case (item_i.command)
      CMD_LOAD: begin
        if (item_i.glyph_index < GLYPH_COUNT) begin
          shape_mem[item_i.glyph_index] = '{advance: item_i.advance,
                                            bearing_y: item_i.bearing_y,
                                            bearing_x: item_i.bearing_x,
                                            height: item_i.glyph_height,
                                            width: item_i.glyph_width};
          place_mem[item_i.glyph_index] = '{atlas_y: item_i.atlas_y,
                                            atlas_x: item_i.atlas_x};
        end
      end
      CMD_BEGIN: begin
        pen_x = item_i.origin_x;
        pen_y = item_i.origin_y;
        start_x = item_i.origin_x;
        line_acc = '0;
      end
      CMD_CHAR: begin
        if (code == NewlineCode) begin
          pen_x = start_x;
          pen_y = pen_y + to_fixed(line_height, 1'b0);
          line_acc = '0;
        end else if (code >= FIRST_CODE && code - FIRST_CODE < GLYPH_COUNT) begin
          slot = code - FIRST_CODE;
          sh = shape_mem[slot];
          pl = place_mem[slot];
          if (sh.width != '0 && sh.height != '0) begin
            gx = pen_x + to_fixed(sh.bearing_x, 1'b1);
            gy = pen_y + to_fixed(ascender, 1'b0) - to_fixed(sh.bearing_y, 1'b1);
            r.drawn = 1'b1;
            r.dest_x = gx;
            r.dest_y = gy;
            r.dest_x_end = gx + to_fixed(sh.width, 1'b0);
            r.dest_y_end = gy + to_fixed(sh.height, 1'b0);
            r.tex_u0 = {pl.atlas_x, 8'h00};
            r.tex_v0 = {pl.atlas_y, 8'h00};
            r.tex_u1 = tex_far(r.tex_u0, sh.width);
            r.tex_v1 = tex_far(r.tex_v0, sh.height);
          end
          pen_x = pen_x + to_fixed(sh.advance, 1'b0);
          sum = {1'b0, line_acc} + {9'd0, sh.advance};
          line_acc = sum[LineW] ? '1 : sum[LineW-1:0];
        end
      end
      default: ;
    endcase
    r.line_width = line_acc;
    expected_q.push_back(r);
  endtask

  task automatic check_field(string name, logic [FixW-1:0] want, logic [FixW-1:0] got);
    if (want !== got) begin
      beat_bad = 1'b1;
      $error("%s: expected %h, got %h", name, want, got);
    end
  endtask

  task automatic check_result();
    result_t want;
    if (expected_q.size() == 0) begin
      mismatches++;
      $error("result beat with no item outstanding");
      return;
    end
    want = expected_q.pop_front();
    beat_bad = 1'b0;
    check_field("drawn", FixW'(want.drawn), FixW'(result_i.drawn));
    check_field("dest_x", want.dest_x, result_i.dest_x);
    check_field("dest_y", want.dest_y, result_i.dest_y);
    check_field("dest_x_end", want.dest_x_end, result_i.dest_x_end);
    check_field("dest_y_end", want.dest_y_end, result_i.dest_y_end);
    check_field("tex_u0", FixW'(want.tex_u0), FixW'(result_i.tex_u0));
    check_field("tex_v0", FixW'(want.tex_v0), FixW'(result_i.tex_v0));
    check_field("tex_u1", FixW'(want.tex_u1), FixW'(result_i.tex_u1));
    check_field("tex_v1", FixW'(want.tex_v1), FixW'(result_i.tex_v1));
    check_field("line_width", FixW'(want.line_width), FixW'(result_i.line_width));
    if (beat_bad) mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x = '0;
      pen_y = '0;
      start_x = '0;
      line_acc = '0;
      line_height = LineHeightRst;
      ascender = AscenderRst;
      texel_inset = TexelInsetRst;
      expected_q.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_LINE_HEIGHT: line_height = cfg_i.data;
          CFG_ASCENDER:    ascender = cfg_i.data;
          CFG_TEXEL_INSET: texel_inset = cfg_i.data;
          default: ;
        endcase
      end
      // Retire the older result before queueing the new beat.
      if (result_i.valid && result_i.ready) check_result();
      if (item_i.valid && item_i.ready) layout_item();
      fail_count_o <= mismatches;
      pending_o <= expected_q.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import btsl_pkg::*;

  localparam int unsigned GlyphCount  = GlyphCountDef;
  localparam int unsigned FirstCode   = FirstCodeDef;
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;
  localparam int PhaseCount    = 5;
  localparam int PhaseItems    = 170;
  localparam int SaturationRun = 300;
  localparam int HoldCycles    = 400;
  localparam int IdlePercent   = 23;
  // Longest legal quiet spell is the receiver hold-off; allow several times that.
  localparam int StallLimit    = 2000;

  typedef struct packed {
    logic [CmdW-1:0]   command;
    logic [IndexW-1:0] glyph_index;
    logic [PixW-1:0]   glyph_width;
    logic [PixW-1:0]   glyph_height;
    logic [PixW-1:0]   bearing_x;
    logic [PixW-1:0]   bearing_y;
    logic [PixW-1:0]   advance;
    logic [AtlasW-1:0] atlas_x;
    logic [AtlasW-1:0] atlas_y;
    logic [FixW-1:0]   origin_x;
    logic [FixW-1:0]   origin_y;
    logic [7:0]        char_code;
  } text_item_t;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   quiet_cycles = 0;
  int   items_sent = 0;
  int   hold_requests = 0;
  int   holds_done = 0;
  bit   tx_steady = 1'b0;
  bit   rx_steady = 1'b0;
  bit   is_loaded [GlyphCount];
  int unsigned loaded_q [$];

  btsl_item_if   item_if ();
  btsl_result_if result_if ();
  btsl_cfg_if    cfg_if ();

  bitmap_text_sprite_layout_core i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  btsl_layout_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item_if),
    .result_i     (result_if),
    .cfg_i        (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < StallLimit) @(posedge clk_i);
    $display("bitmap_text_sprite_layout_core: mismatch");
    $finish;
  end

  // Result side: random back-pressure, a steady stretch, and long hold-offs on request.
  initial begin
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_requests != holds_done) begin
        holds_done++;
        result_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        result_if.ready <= rx_steady || ($urandom_range(99) >= IdlePercent);
      end
    end
  end

  function automatic text_item_t noise_item();
    text_item_t it;
    it.command      = CmdW'($urandom);
    it.glyph_index  = IndexW'($urandom);
    it.glyph_width  = PixW'($urandom);
    it.glyph_height = PixW'($urandom);
    it.bearing_x    = PixW'($urandom);
    it.bearing_y    = PixW'($urandom);
    it.advance      = PixW'($urandom);
    it.atlas_x      = AtlasW'($urandom);
    it.atlas_y      = AtlasW'($urandom);
    it.origin_x     = FixW'($urandom);
    it.origin_y     = FixW'($urandom);
    it.char_code    = 8'($urandom);
    return it;
  endfunction

  task automatic send_item(text_item_t it);
    while (!tx_steady && $urandom_range(99) < IdlePercent) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid        <= 1'b1;
    item_if.command      <= it.command;
    item_if.glyph_index  <= it.glyph_index;
    item_if.glyph_width  <= it.glyph_width;
    item_if.glyph_height <= it.glyph_height;
    item_if.bearing_x    <= it.bearing_x;
    item_if.bearing_y    <= it.bearing_y;
    item_if.advance      <= it.advance;
    item_if.atlas_x      <= it.atlas_x;
    item_if.atlas_y      <= it.atlas_y;
    item_if.origin_x     <= it.origin_x;
    item_if.origin_y     <= it.origin_y;
    item_if.char_code    <= it.char_code;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    if (it.command != CmdUnused) items_sent++;
  endtask

  task automatic send_load(int unsigned idx, logic [7:0] w, logic [7:0] h, logic [7:0] bx,
                           logic [7:0] by, logic [7:0] adv, logic [11:0] ax, logic [11:0] ay);
    text_item_t it;
    it = noise_item();
    it.command = CMD_LOAD;
    it.glyph_index = IndexW'(idx);
    it.glyph_width = w;
    it.glyph_height = h;
    it.bearing_x = bx;
    it.bearing_y = by;
    it.advance = adv;
    it.atlas_x = ax;
    it.atlas_y = ay;
    send_item(it);
    if (idx < GlyphCount && !is_loaded[idx]) begin
      is_loaded[idx] = 1'b1;
      loaded_q.push_back(idx);
    end
  endtask

  task automatic random_load(int unsigned idx);
    logic [7:0] w;
    logic [7:0] h;
    w = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom);
    h = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom);
    send_load(idx, w, h, 8'($urandom), 8'($urandom), 8'($urandom), 12'($urandom),
              12'($urandom));
  endtask

  task automatic send_begin(logic [FixW-1:0] ox, logic [FixW-1:0] oy);
    text_item_t it;
    it = noise_item();
    it.command = CMD_BEGIN;
    it.origin_x = ox;
    it.origin_y = oy;
    send_item(it);
  endtask

  task automatic send_char(logic [7:0] code);
    text_item_t it;
    it = noise_item();
    it.command = CMD_CHAR;
    it.char_code = code;
    send_item(it);
  endtask

  task automatic send_unused();
    text_item_t it;
    it = noise_item();
    it.command = CmdUnused;
    send_item(it);
  endtask

  function automatic logic [FixW-1:0] random_origin();
    case ($urandom_range(7))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'hFFFF00;
      3: return '0;
      default: return FixW'($urandom);
    endcase
  endfunction

  // Codes outside the glyph range: below the first glyph or past the last one.
  function automatic logic [7:0] stray_code();
    if ($urandom_range(1) == 0) return 8'($urandom_range(FirstCode - 1));
    return 8'($urandom_range(255, FirstCode + GlyphCount));
  endfunction

  // Only loaded entries are ever looked up.
  function automatic logic [7:0] pick_code();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8) return NewlineCode;
    if (pick < 16 || loaded_q.size() == 0) return stray_code();
    return 8'(FirstCode + loaded_q[$urandom_range(loaded_q.size() - 1)]);
  endfunction

  task automatic set_register(cfg_idx_e idx, logic [CfgW-1:0] value);
    // Drop the last item beat so it is not taken again.
    item_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic random_phase(int count);
    int          base;
    int unsigned pick;
    base = items_sent;
    while (items_sent - base < count) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        repeat ($urandom_range(1, 4)) begin
          random_load(($urandom_range(9) == 0) ? $urandom_range(127, GlyphCount)
                                               : $urandom_range(GlyphCount - 1));
        end
      end else if (pick < 80) begin
        send_begin(random_origin(), random_origin());
        repeat ($urandom_range(1, 30)) send_char(pick_code());
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 10)) send_char(pick_code());
      end else if ($urandom_range(1) == 0) begin
        send_unused();
      end else begin
        send_char(stray_code());
      end
    end
  endtask

  initial begin
    logic [CfgW-1:0] lh;
    logic [CfgW-1:0] asc;
    logic [CfgW-1:0] ins;

    rst_ni               <= 1'b0;
    item_if.valid        <= 1'b0;
    item_if.command      <= CMD_LOAD;
    item_if.glyph_index  <= '0;
    item_if.glyph_width  <= '0;
    item_if.glyph_height <= '0;
    item_if.bearing_x    <= '0;
    item_if.bearing_y    <= '0;
    item_if.advance      <= '0;
    item_if.atlas_x      <= '0;
    item_if.atlas_y      <= '0;
    item_if.origin_x     <= '0;
    item_if.origin_y     <= '0;
    item_if.char_code    <= '0;
    cfg_if.valid         <= 1'b0;
    cfg_if.index         <= CFG_LINE_HEIGHT;
    cfg_if.data          <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: stray codes and newline from reset, unused command, ignored loads.
    send_char(8'd0);
    send_char(8'd255);
    send_char(NewlineCode);
    send_unused();
    random_load(127);
    random_load(GlyphCount);
    // Field extremes, texture clamp, zero-size glyphs that still advance.
    send_load(0, 8'd255, 8'd255, 8'h80, 8'h7F, 8'd255, 12'hFFF, 12'hFFF);
    send_load(GlyphCount - 1, 8'd0, 8'd5, 8'h03, 8'h04, 8'd7, 12'h123, 12'h456);
    send_load(1, 8'd1, 8'd1, 8'h7F, 8'h80, 8'd0, 12'h000, 12'h000);
    send_load(2, 8'd3, 8'd0, 8'h01, 8'h02, 8'd9, 12'h800, 12'h7FF);
    send_begin(24'h7FFFFF, 24'h800000);
    send_char(8'(FirstCode));
    send_char(8'(FirstCode + 1));
    send_char(8'(FirstCode + GlyphCount - 1));
    send_char(8'(FirstCode + 2));
    send_char(NewlineCode);
    send_char(8'(FirstCode));
    send_char(8'(FirstCode));
    // Pen wraps past the top of the coordinate range.
    send_begin(24'hFFFF00, 24'hFFFFFF);
    send_char(8'(FirstCode));
    send_char(8'(FirstCode + 1));
    send_char(8'(FirstCode - 1));
    send_char(8'(FirstCode + GlyphCount));
    send_char(8'd200);

    for (int unsigned i = 0; i < GlyphCount; i++) random_load(i);

    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0: begin
          lh = '0;
          asc = '0;
          ins = '0;
        end
        1: begin
          lh = '1;
          asc = '1;
          ins = '1;
        end
        PhaseCount - 1: begin
          lh = LineHeightRst;
          asc = AscenderRst;
          ins = TexelInsetRst;
        end
        default: begin
          lh = CfgW'($urandom);
          asc = CfgW'($urandom);
          ins = CfgW'($urandom);
        end
      endcase
      set_register(CFG_LINE_HEIGHT, lh);
      set_register(CFG_ASCENDER, asc);
      set_register(CFG_TEXEL_INSET, ins);
      if (p == 2) begin
        tx_steady = 1'b1;
        rx_steady = 1'b1;
      end
      // Hold the result side off while items keep coming, so the input backs up.
      if (p == 3) hold_requests++;
      random_phase(PhaseItems);
      if (p == 2) begin
        // One long line of wide advances drives the line width into saturation.
        send_load(0, 8'd4, 8'd4, 8'($urandom), 8'($urandom), 8'd255, 12'($urandom),
                  12'($urandom));
        send_begin(random_origin(), random_origin());
        repeat (SaturationRun) send_char(8'(FirstCode));
        tx_steady = 1'b0;
        rx_steady = 1'b0;
      end
    end

    item_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("bitmap_text_sprite_layout_core: match");
    end else begin
      $display("bitmap_text_sprite_layout_core: mismatch");
    end
    $finish;
  end

endmodule
